FILE: rtl/x86rel_pkg.sv
package x86rel_pkg;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_LOOP  = 2'd2
  } status_t;

  localparam logic [7:0] MODRM_RIP_MASK  = 8'hC7;
  localparam logic [7:0] MODRM_RIP_VALUE = 8'h05;
  localparam logic [7:0] OP_JMP_REL8     = 8'hEB;
  localparam logic [7:0] OP_JMP_REL32    = 8'hE9;
  localparam logic [7:0] OP_CALL_REL32   = 8'hE8;
  localparam logic [7:0] OP_HIGH_MASK    = 8'hF0;
  localparam logic [7:0] OP_JCC_SHORT    = 8'h70;
  localparam logic [7:0] OP_ESCAPE       = 8'h0F;
  localparam logic [7:0] OP_JCC_NEAR     = 8'h80;
  localparam logic [7:0] OP_LOOP_MASK    = 8'hFC;
  localparam logic [7:0] OP_LOOP_BASE    = 8'hE0;
  localparam logic [7:0] OP_INDIRECT     = 8'hFF;
  localparam logic [7:0] MODRM_JMP_ABS   = 8'h25;
  localparam logic [7:0] MODRM_CALL_ABS  = 8'h15;
  localparam logic [7:0] CALL_SKIP_DISP  = 8'h02;
  localparam logic [7:0] JMP_SKIP_ADDR   = 8'h08;
  localparam logic [7:0] JCC_SKIP_JUMP   = 8'h0E;

  localparam int unsigned BUF_BYTES  = 16;
  localparam int unsigned INSN_BYTES = 15;

  typedef logic [7:0] code_buf_t [BUF_BYTES];

endpackage

FILE: rtl/x86_instruction_relocator_core.sv
// Relocates one decoded x86-64 instruction per input beat and streams the
// rewritten code one byte per output beat, final_byte marking the last byte of
// the instruction. Rip-relative operands are re-based, relative jmp, call and
// conditional branches are expanded into indirect jumps through an embedded
// 64-bit address (address_field_start marks its first byte), loop opcodes and
// out-of-range displacements give one zero byte carrying the error status, and
// anything else is copied; a copy of length zero gives no output. An input
// beat reaches the output through an input register, a decode register and
// the output buffer. The buffer drains one byte per cycle while out_ready is
// high; an instruction holds it until its output bytes are all taken, 1 to 15
// for copies and errors, 14 for jmp, 16 for call and conditional branches, and
// that drain sets the sustained intake.
module x86_instruction_relocator_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [63:0]  insn_bytes_low,
  input  logic [55:0]  insn_bytes_high,
  input  logic [3:0]   insn_length,
  input  logic [7:0]   modrm_byte,
  input  logic [7:0]   opcode_first,
  input  logic [7:0]   opcode_second,
  input  logic [3:0]   disp_position,
  input  logic [3:0]   imm_position,
  input  logic [63:0]  source_address,
  input  logic [63:0]  target_address,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   code_byte,
  output logic         final_byte,
  output logic [1:0]   status,
  output logic         address_field_start
);
  import x86rel_pkg::*;

  // input register
  logic         v1;
  logic [63:0]  lo1;
  logic [55:0]  hi1;
  logic [3:0]   len1;
  logic [7:0]   modrm1;
  logic [7:0]   op0_1;
  logic [7:0]   op1_1;
  logic [3:0]   dpos1;
  logic [3:0]   ipos1;
  logic [63:0]  src1;
  logic [63:0]  dst1;

  // decode register
  logic         v2;
  code_buf_t    buf2;
  logic [4:0]   cnt2;
  logic [3:0]   addr2;
  logic         has_addr2;
  logic         rip2;
  logic         loop2;
  logic [3:0]   dpos2;
  logic [63:0]  a2;
  logic [63:0]  b2;

  // output buffer
  logic         v3;
  code_buf_t    buf3;
  logic [3:0]   last3;
  logic [3:0]   addr3;
  logic         has_addr3;
  logic         err3;
  status_t      status3;
  logic [3:0]   idx3;

  logic         out_last;
  logic         s3_free;
  logic         move2;
  logic         move1;
  logic         take_in;

  assign out_last = (idx3 == last3);
  assign s3_free  = !v3 || (out_ready && out_last);
  assign move2    = v2 && s3_free;
  assign move1    = v1 && (!v2 || move2);
  assign in_ready = !v1 || move1;
  assign take_in  = in_valid && in_ready;

  // stage 1 decode
  logic [151:0] ext1;
  logic [31:0]  disp_word;
  logic [31:0]  imm_word;
  logic         imm_wide;
  logic [63:0]  imm64;
  logic [63:0]  len64;
  logic [63:0]  jump_target;
  logic [63:0]  a_val;
  logic [63:0]  b_val;
  logic         is_rip;
  logic         is_jmp;
  logic         is_call;
  logic         is_jcc_short;
  logic         is_jcc_near;
  logic         is_loop;
  code_buf_t    buf_next;
  logic [4:0]   cnt_next;
  logic [3:0]   addr_next;
  logic         has_addr_next;

  assign ext1      = {32'h0, hi1, lo1};
  assign disp_word = 32'(ext1 >> {dpos1, 3'b000});
  assign imm_word  = 32'(ext1 >> {ipos1, 3'b000});
  assign imm_wide  = (op0_1 == OP_JMP_REL32) || (op0_1 == OP_CALL_REL32) ||
                     (op0_1 == OP_ESCAPE);
  assign imm64     = imm_wide ? {{32{imm_word[31]}}, imm_word}
                              : {{56{imm_word[7]}}, imm_word[7:0]};
  assign len64       = {60'h0, len1};
  assign jump_target = src1 + len64 + imm64;
  assign a_val       = src1 + len64 + {{32{disp_word[31]}}, disp_word};
  assign b_val       = dst1 + len64;

  assign is_rip       = (modrm1 & MODRM_RIP_MASK) == MODRM_RIP_VALUE;
  assign is_jmp       = (op0_1 == OP_JMP_REL8) || (op0_1 == OP_JMP_REL32);
  assign is_call      = (op0_1 == OP_CALL_REL32);
  assign is_jcc_short = (op0_1 & OP_HIGH_MASK) == OP_JCC_SHORT;
  assign is_jcc_near  = (op0_1 == OP_ESCAPE) && ((op1_1 & OP_HIGH_MASK) == OP_JCC_NEAR);
  assign is_loop      = (op0_1 & OP_LOOP_MASK) == OP_LOOP_BASE;

  always_comb begin
    for (int k = 0; k < BUF_BYTES; k++) begin
      buf_next[k] = 8'h00;
    end
    cnt_next      = {1'b0, len1};
    addr_next     = 4'd0;
    has_addr_next = 1'b0;
    priority if (is_rip) begin
      for (int k = 0; k < INSN_BYTES; k++) begin
        buf_next[k] = ext1[8*k +: 8];
      end
    end else if (is_jmp) begin
      buf_next[0] = OP_INDIRECT;
      buf_next[1] = MODRM_JMP_ABS;
      for (int k = 0; k < 8; k++) begin
        buf_next[6+k] = jump_target[8*k +: 8];
      end
      cnt_next      = 5'd14;
      addr_next     = 4'd6;
      has_addr_next = 1'b1;
    end else if (is_call) begin
      buf_next[0] = OP_INDIRECT;
      buf_next[1] = MODRM_CALL_ABS;
      buf_next[2] = CALL_SKIP_DISP;
      buf_next[6] = OP_JMP_REL8;
      buf_next[7] = JMP_SKIP_ADDR;
      for (int k = 0; k < 8; k++) begin
        buf_next[8+k] = jump_target[8*k +: 8];
      end
      cnt_next      = 5'd16;
      addr_next     = 4'd8;
      has_addr_next = 1'b1;
    end else if (is_jcc_short || is_jcc_near) begin
      buf_next[0] = is_jcc_short ? (op0_1 ^ 8'h01)
                                 : (OP_JCC_SHORT | {4'h0, op1_1[3:0] ^ 4'h1});
      buf_next[1] = JCC_SKIP_JUMP;
      buf_next[2] = OP_INDIRECT;
      buf_next[3] = MODRM_JMP_ABS;
      for (int k = 0; k < 8; k++) begin
        buf_next[8+k] = jump_target[8*k +: 8];
      end
      cnt_next      = 5'd16;
      addr_next     = 4'd8;
      has_addr_next = 1'b1;
    end else if (is_loop) begin
      cnt_next = 5'd1;
    end else begin
      for (int k = 0; k < INSN_BYTES; k++) begin
        buf_next[k] = ext1[8*k +: 8];
      end
    end
  end

  // stage 2 range check and displacement patch
  logic [64:0]  diff;
  logic         range_err;
  logic [31:0]  new_disp;
  code_buf_t    patched;
  logic [4:0]   rel;

  assign diff      = {1'b0, a2} - {1'b0, b2};
  assign range_err = diff[64] ? !(&diff[63:31]) : (|diff[63:31]);
  assign new_disp  = diff[31:0];

  always_comb begin
    patched = buf2;
    rel     = 5'd0;
    if (rip2) begin
      for (int j = 0; j < INSN_BYTES; j++) begin
        rel = 5'(j) - {1'b0, dpos2};
        if ((5'(j) >= {1'b0, dpos2}) && (rel < 5'd4)) begin
          patched[j] = new_disp[8*rel[1:0] +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (take_in) begin
      v1 <= 1'b1;
    end else if (move1) begin
      v1 <= 1'b0;
    end
    if (take_in) begin
      lo1    <= insn_bytes_low;
      hi1    <= insn_bytes_high;
      len1   <= insn_length;
      modrm1 <= modrm_byte;
      op0_1  <= opcode_first;
      op1_1  <= opcode_second;
      dpos1  <= disp_position;
      ipos1  <= imm_position;
      src1   <= source_address;
      dst1   <= target_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (move1) begin
      v2 <= 1'b1;
    end else if (move2) begin
      v2 <= 1'b0;
    end
    if (move1) begin
      buf2      <= buf_next;
      cnt2      <= cnt_next;
      addr2     <= addr_next;
      has_addr2 <= has_addr_next;
      rip2      <= is_rip;
      loop2     <= !is_rip && !is_jmp && !is_call && !is_jcc_short && !is_jcc_near &&
                   is_loop;
      dpos2     <= dpos1;
      a2        <= a_val;
      b2        <= b_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3   <= 1'b0;
      idx3 <= 4'd0;
    end else if (move2) begin
      // drop copies of length zero
      v3   <= (cnt2 != 5'd0) || (rip2 && range_err);
      idx3 <= 4'd0;
    end else if (v3 && out_ready) begin
      if (out_last) begin
        v3 <= 1'b0;
      end else begin
        idx3 <= idx3 + 4'd1;
      end
    end
    if (move2) begin
      buf3      <= patched;
      addr3     <= addr2;
      has_addr3 <= has_addr2;
      if (loop2) begin
        err3    <= 1'b1;
        status3 <= STATUS_LOOP;
        last3   <= 4'd0;
      end else if (rip2 && range_err) begin
        err3    <= 1'b1;
        status3 <= STATUS_RANGE;
        last3   <= 4'd0;
      end else begin
        err3    <= 1'b0;
        status3 <= STATUS_OK;
        last3   <= 4'(cnt2 - 5'd1);
      end
    end
  end

  assign out_valid           = v3;
  assign code_byte           = err3 ? 8'h00 : buf3[idx3];
  assign final_byte          = out_last;
  assign status              = status3;
  assign address_field_start = !err3 && has_addr3 && (idx3 == addr3);

endmodule
